@@ rtl/rsn_pkg.sv @@
// Shared types and constants of the raw sample normalizer.
// Used by the configuration interface, the divider and the top level.
package rsn_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SAMPLE_FORMAT = 3'd0,
		REG_SAMPLES_SIGNED = 3'd1,
		REG_SWAP_BYTES = 3'd2,
		REG_SCALE_FACTOR = 3'd3,
		REG_OFFSET_VALUE = 3'd4,
		REG_NORM_LOW = 3'd5,
		REG_NORM_HIGH = 3'd6
	} rsn_reg_t;

	// sample format codes
	localparam logic [1:0] FMT_U8 = 2'd0;
	localparam logic [1:0] FMT_16 = 2'd1;
	localparam logic [1:0] FMT_F32 = 2'd2;

	// reset values
	localparam logic [31:0] SCALE_RESET = 32'h0001_0000;
	localparam logic [31:0] NORM_HIGH_RESET = 32'h0001_0000;

	// signed 16-bit special codes
	localparam logic [15:0] S16_NULL = 16'h8000;   // -32768
	localparam logic [15:0] S16_LOW_A = 16'h8001;  // -32767
	localparam logic [15:0] S16_LOW_B = 16'h8002;  // -32766
	localparam logic [15:0] S16_HIGH_A = 16'h8004; // -32764
	localparam logic [15:0] S16_HIGH_B = 16'h8003; // -32765

	// float special codes
	localparam logic [31:0] F32_NULL = 32'hFF7F_FFFB;
	localparam logic [31:0] F32_ZERO_A = 32'hFF7F_FFFC;
	localparam logic [31:0] F32_ZERO_B = 32'hFF7F_FFFD;
	localparam logic [31:0] F32_ONE_A = 32'hFF7F_FFFE;
	localparam logic [31:0] F32_ONE_B = 32'hFF7F_FFFF;

	// divider shape: 32 quotient bits, two per stage
	localparam int QUO_W = 32;
	localparam int DIV_STEPS = 2;

	// flags that travel with an item down the pipeline
	typedef struct packed {
		logic bad;    // unknown format code
		logic valid;  // sample usable
		logic clip;   // saturation seen so far
		logic nn;     // numerator negative
		logic nz;     // numerator nonzero
		logic ovf;    // quotient at least 2^32
		logic zspan;  // zero normalization span
	} rsn_side_t;

endpackage

@@ rtl/rsn_sample_if.sv @@
// Input channel of the raw sample normalizer: one raw word per beat.
// Depends on nothing.
interface rsn_sample_if;
	logic        valid;
	logic        ready;
	logic [31:0] raw_word;

	modport source (output valid, output raw_word, input ready);
	modport sink (input valid, input raw_word, output ready);
endinterface

@@ rtl/rsn_result_if.sv @@
// Result channel of the raw sample normalizer: one normalized value per beat.
// Depends on nothing.
interface rsn_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] norm_value;
	logic               sample_valid;
	logic               clipped;

	modport source (output valid, output norm_value, output sample_valid, output clipped,
		input ready);
	modport sink (input valid, input norm_value, input sample_valid, input clipped,
		output ready);
endinterface

@@ rtl/rsn_cfg_if.sv @@
// Configuration write channel of the raw sample normalizer.
// Depends on rsn_pkg for the index width.
interface rsn_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [rsn_pkg::CFG_IDX_W-1:0] index;
	logic [31:0]                    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/raw_sample_normalizer.sv @@
// Top level of the raw sample normalizer: config registers, decode, scale, divide.
// Depends on rsn_pkg, the three channel interfaces and rsn_div.
//
// Usage: configuration beats on cfg write the seven registers by index (ready is
// always high, index 7 is ignored); write them only while no sample is in flight.
// Each beat on samples carries one raw word; each beat on results carries the
// normalized Q16.16 value with its sample_valid and clipped flags, in order.
// Throughput: one sample per cycle while results is not stalled. A sample passes
// through decode, multiply, add and range check, sixteen divider stages of two
// quotient bits each, and the output register, in that order.
// The 32-bit quotient of the numerator by the normalization span sets the depth.
// When results is stalled the whole pipeline holds in place and samples.ready
// drops; nothing is lost or repeated. Reset empties the pipeline and loads the
// register reset values: 8-bit unsigned, no swap, scale 1.0, offset 0, range 0..1.
module raw_sample_normalizer (
	input  logic        clk,
	input  logic        arst_n,
	rsn_sample_if.sink  samples,
	rsn_result_if.source results,
	rsn_cfg_if.sink     cfg
);
	// configuration registers
	logic [1:0]  sample_format_q;
	logic        samples_signed_q;
	logic        swap_bytes_q;
	logic [31:0] scale_factor_q;
	logic [31:0] offset_value_q;
	logic [31:0] norm_low_q;
	logic [31:0] norm_high_q;

	// derived magnitudes of the configuration
	logic        sn_q;
	logic [31:0] sm_q;
	logic        dn_q;
	logic [32:0] dm_q;
	logic        spn_q;
	logic [32:0] spm_q;

	logic adv;

	assign cfg.ready = 1'b1;

	// write registers by index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_format_q <= rsn_pkg::FMT_U8;
			samples_signed_q <= 1'b0;
			swap_bytes_q <= 1'b0;
			scale_factor_q <= rsn_pkg::SCALE_RESET;
			offset_value_q <= '0;
			norm_low_q <= '0;
			norm_high_q <= rsn_pkg::NORM_HIGH_RESET;
		end else if (cfg.valid) begin
			unique case (rsn_pkg::rsn_reg_t'(cfg.index))
				rsn_pkg::REG_SAMPLE_FORMAT: sample_format_q <= cfg.data[1:0];
				rsn_pkg::REG_SAMPLES_SIGNED: samples_signed_q <= cfg.data[0];
				rsn_pkg::REG_SWAP_BYTES: swap_bytes_q <= cfg.data[0];
				rsn_pkg::REG_SCALE_FACTOR: scale_factor_q <= cfg.data;
				rsn_pkg::REG_OFFSET_VALUE: offset_value_q <= cfg.data;
				rsn_pkg::REG_NORM_LOW: norm_low_q <= cfg.data;
				rsn_pkg::REG_NORM_HIGH: norm_high_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// precompute sign and magnitude of scale, offset term and span
	logic [32:0] diff_d;
	logic [32:0] span_d;
	assign diff_d = 33'({offset_value_q[31], offset_value_q} - {norm_low_q[31], norm_low_q});
	assign span_d = 33'({norm_high_q[31], norm_high_q} - {norm_low_q[31], norm_low_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sn_q <= 1'b0;
			sm_q <= rsn_pkg::SCALE_RESET;
			dn_q <= 1'b0;
			dm_q <= '0;
			spn_q <= 1'b0;
			spm_q <= {1'b0, rsn_pkg::NORM_HIGH_RESET};
		end else begin
			sn_q <= scale_factor_q[31];
			sm_q <= scale_factor_q[31] ? 32'(-scale_factor_q) : scale_factor_q;
			dn_q <= diff_d[32];
			dm_q <= diff_d[32] ? 33'(-diff_d) : diff_d;
			spn_q <= span_d[32];
			spm_q <= span_d[32] ? 33'(-span_d) : span_d;
		end
	end

	// stall everything when the output register is full and not taken
	assign adv = !results.valid || results.ready;
	assign samples.ready = adv;

	// stage 1: decode the raw word into sign and Q16.16 magnitude
	logic [31:0]        raw;
	logic [15:0]        h;
	logic [31:0]        w;
	logic               kn_d;
	logic [31:0]        km_d;
	rsn_pkg::rsn_side_t side_d;
	logic [8:0]         v9;
	logic [8:0]         m9;
	logic [16:0]        v17;
	logic [16:0]        m17;
	logic [7:0]         fe;
	logic [23:0]        man;
	logic [24:0]        ft;
	logic [32:0]        fm;
	logic               fneg;
	logic [32:0]        flim;

	assign raw = samples.raw_word;
	assign h = swap_bytes_q ? {raw[7:0], raw[15:8]} : raw[15:0];
	assign w = swap_bytes_q ? {raw[7:0], raw[15:8], raw[23:16], raw[31:24]} : raw;
	assign fe = w[30:23];
	assign man = {1'b1, w[22:0]};

	always_comb begin
		kn_d = 1'b0;
		km_d = '0;
		side_d = '0;
		side_d.valid = 1'b1;
		v9 = {samples_signed_q & raw[7], raw[7:0]};
		m9 = v9[8] ? 9'(-v9) : v9;
		v17 = {samples_signed_q & h[15], h};
		m17 = v17[16] ? 17'(-v17) : v17;
		ft = '0;
		fm = '0;
		fneg = 1'b0;
		flim = '0;
		case (sample_format_q)
			rsn_pkg::FMT_U8: begin
				kn_d = v9[8];
				km_d = {7'b0, m9, 16'b0};
			end
			rsn_pkg::FMT_16: begin
				if (samples_signed_q && h == rsn_pkg::S16_NULL) begin
					side_d.valid = 1'b0;
				end else if (samples_signed_q &&
					(h == rsn_pkg::S16_LOW_A || h == rsn_pkg::S16_LOW_B)) begin
					kn_d = 1'b1;
					km_d = 32'h8000_0000;
				end else if (samples_signed_q &&
					(h == rsn_pkg::S16_HIGH_A || h == rsn_pkg::S16_HIGH_B)) begin
					km_d = 32'h7FFF_0000;
				end else begin
					kn_d = v17[16];
					km_d = {m17[15:0], 16'b0};
				end
			end
			rsn_pkg::FMT_F32: begin
				if (w == rsn_pkg::F32_NULL) begin
					side_d.valid = 1'b0;
				end else if (w == rsn_pkg::F32_ZERO_A || w == rsn_pkg::F32_ZERO_B) begin
					km_d = '0;
				end else if (w == rsn_pkg::F32_ONE_A || w == rsn_pkg::F32_ONE_B) begin
					km_d = 32'h0001_0000;
				end else if (fe != 8'h00 && fe != 8'hFF) begin
					// convert to Q16.16 with round half away from zero
					if (fe > 8'd142) begin
						fm = 33'h1_0000_0000;
					end else if (fe >= 8'd134) begin
						fm = 33'(man) << 4'(fe - 8'd134);
					end else begin
						ft = {man, 1'b0} >> (8'd134 - fe);
						fm = 33'((26'(ft) + 26'd1) >> 1);
					end
					fneg = w[31] && (fm != '0);
					flim = fneg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
					if (fm > flim) begin
						fm = flim;
						side_d.clip = 1'b1;
					end
					kn_d = fneg;
					km_d = fm[31:0];
				end else begin
					side_d.valid = 1'b0;
				end
			end
			default: begin
				side_d.bad = 1'b1;
				side_d.valid = 1'b0;
			end
		endcase
	end

	logic               v_s1;
	logic               kn_s1;
	logic [31:0]        km_s1;
	rsn_pkg::rsn_side_t side_s1;

	// stage 2: product magnitude
	logic               v_s2;
	logic               kn_s2;
	logic [63:0]        pm_s2;
	rsn_pkg::rsn_side_t side_s2;

	// stage 3: signed-magnitude sum
	logic               v_s3;
	logic [63:0]        nm_s3;
	rsn_pkg::rsn_side_t side_s3;

	// stage 4: range check before the divider
	logic               v_s4;
	logic [63:0]        nm_s4;
	rsn_pkg::rsn_side_t side_s4;

	logic               pn;
	logic [63:0]        bm;
	logic [63:0]        nm_d;
	logic               nn_d;
	rsn_pkg::rsn_side_t side3_d;
	rsn_pkg::rsn_side_t side4_d;

	assign pn = (pm_s2 != '0) && (kn_s2 ^ sn_q);
	assign bm = {15'b0, dm_q, 16'b0};

	always_comb begin
		if (pn == dn_q) begin
			nm_d = pm_s2 + bm;
			nn_d = pn;
		end else if (pm_s2 >= bm) begin
			nm_d = pm_s2 - bm;
			nn_d = pn;
		end else begin
			nm_d = bm - pm_s2;
			nn_d = dn_q;
		end
	end

	// merge the flags produced by stages 3 and 4
	always_comb begin
		side3_d = side_s2;
		side3_d.nn = nn_d;
		side4_d = side_s3;
		side4_d.nz = (nm_s3 != '0);
		side4_d.ovf = ({1'b0, nm_s3[63:32]} >= spm_q);
		side4_d.zspan = (spm_q == '0);
	end

	// advance pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= samples.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// advance pipeline payload
	always_ff @(posedge clk) begin
		if (adv) begin
			kn_s1 <= kn_d;
			km_s1 <= km_d;
			side_s1 <= side_d;

			kn_s2 <= kn_s1;
			pm_s2 <= 64'(km_s1) * 64'(sm_q);
			side_s2 <= side_s1;

			nm_s3 <= nm_d;
			side_s3 <= side3_d;

			nm_s4 <= nm_s3;
			side_s4 <= side4_d;
		end
	end

	// divide the numerator by the span
	logic               v_dv;
	logic [31:0]        quo;
	logic [32:0]        rem;
	rsn_pkg::rsn_side_t side_dv;

	rsn_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.in_valid  (v_s4),
		.num       (nm_s4),
		.den       (spm_q),
		.in_side   (side_s4),
		.out_valid (v_dv),
		.quo       (quo),
		.rem       (rem),
		.out_side  (side_dv)
	);

	// round, sign, saturate; force the zero-span and unknown-format results
	logic [32:0] qm;
	logic        qn;
	logic [32:0] qlim;
	logic [31:0] value_d;
	logic        clip_d;
	logic        valid_d;

	always_comb begin
		qm = {1'b0, quo} + 33'({rem, 1'b0} >= {1'b0, spm_q});
		if (side_dv.ovf) qm = 33'h1_0000_0000;
		qn = (qm != '0) && (side_dv.nn ^ spn_q);
		qlim = qn ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
		clip_d = side_dv.clip;
		if (qm > qlim) begin
			qm = qlim;
			clip_d = 1'b1;
		end
		value_d = qn ? 32'(-qm[31:0]) : qm[31:0];
		valid_d = side_dv.valid;
		if (side_dv.zspan) begin
			clip_d = 1'b1;
			if (!side_dv.nz) value_d = '0;
			else if (side_dv.nn) value_d = 32'h8000_0000;
			else value_d = 32'h7FFF_FFFF;
		end
		if (side_dv.bad) begin
			value_d = '0;
			clip_d = 1'b0;
			valid_d = 1'b0;
		end
	end

	// output register
	logic        out_valid_q;
	logic [31:0] out_value_q;
	logic        out_sample_valid_q;
	logic        out_clipped_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= v_dv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_value_q <= value_d;
			out_sample_valid_q <= valid_d;
			out_clipped_q <= clip_d;
		end
	end

	assign results.valid = out_valid_q;
	assign results.norm_value = out_value_q;
	assign results.sample_valid = out_sample_valid_q;
	assign results.clipped = out_clipped_q;
endmodule

@@ rtl/rsn_div.sv @@
// Pipelined restoring divider: 64-bit numerator by 33-bit divisor, 32 quotient bits.
// Depends on rsn_pkg. Caller guarantees num[63:32] < den for a meaningful result.
module rsn_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                in_valid,
	input  logic [63:0]         num,
	input  logic [32:0]         den,
	input  rsn_pkg::rsn_side_t  in_side,
	output logic                out_valid,
	output logic [31:0]         quo,
	output logic [32:0]         rem,
	output rsn_pkg::rsn_side_t  out_side
);
	localparam int Stages = rsn_pkg::QUO_W / rsn_pkg::DIV_STEPS;

	logic               vld_s [Stages];
	logic [32:0]        pr_s [Stages];
	logic [31:0]        w_s [Stages];
	rsn_pkg::rsn_side_t side_s [Stages];

	logic [32:0] pr_d [Stages];
	logic [31:0] w_d [Stages];

	// run DIV_STEPS shift-subtract steps in each stage
	always_comb begin
		logic [32:0] p;
		logic [31:0] w;
		logic [33:0] t;
		logic        ge;
		for (int j = 0; j < Stages; j++) begin
			if (j == 0) begin
				p = {1'b0, num[63:32]};
				w = num[31:0];
			end else begin
				p = pr_s[j-1];
				w = w_s[j-1];
			end
			for (int k = 0; k < rsn_pkg::DIV_STEPS; k++) begin
				t = {p, w[31]};
				ge = (t >= {1'b0, den});
				w = {w[30:0], ge};
				p = ge ? 33'(t - {1'b0, den}) : t[32:0];
			end
			pr_d[j] = p;
			w_d[j] = w;
		end
	end

	// advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < Stages; j++) vld_s[j] <= 1'b0;
		end else if (adv) begin
			for (int j = 0; j < Stages; j++) begin
				if (j == 0) vld_s[j] <= in_valid;
				else vld_s[j] <= vld_s[j-1];
			end
		end
	end

	// advance partial remainders, quotient bits and flags
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int j = 0; j < Stages; j++) begin
				pr_s[j] <= pr_d[j];
				w_s[j] <= w_d[j];
				if (j == 0) side_s[j] <= in_side;
				else side_s[j] <= side_s[j-1];
			end
		end
	end

	assign out_valid = vld_s[Stages-1];
	assign quo = w_s[Stages-1];
	assign rem = pr_s[Stages-1];
	assign out_side = side_s[Stages-1];
endmodule

@@ verif/raw_sample_normalizer_tb.sv @@
// Self-checking testbench of the raw sample normalizer: directed and random raw words under
// several register settings, each result checked against an in-bench Q16.16 normalizer.
// Depends on rsn_pkg, the three channel interfaces and the raw_sample_normalizer RTL.
module raw_sample_normalizer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [31:0] norm_value;
		logic        sample_valid;
		logic        clipped;
	} norm_result_t;

	typedef struct {
		bit                 is_cfg;
		rsn_pkg::rsn_reg_t  reg_idx;
		logic [31:0]        word;
	} pending_beat_t;

	localparam int LATENCY = 21;
	localparam int STALL_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rsn_sample_if samples();
	rsn_result_if results();
	rsn_cfg_if    cfg();

	raw_sample_normalizer u_dut (
		.clk(clk), .arst_n(arst_n), .samples(samples), .results(results), .cfg(cfg)
	);

	always #5 clk = ~clk;

	// local copy of the register file
	logic [1:0]  fmt_r;
	logic        signed_r, swap_r;
	logic [31:0] scale_r, offset_r, low_r, high_r;

	pending_beat_t pending_q[$];
	norm_result_t  expected_q[$];
	int  errors = 0;
	int  idle_cycles = 0;
	int  sample_gap = 0, result_gap = 0;
	int  drain_cnt = 0;
	bit  sample_taken = 1'b0;
	bit  cfg_taken = 1'b0;

	function automatic bit u_busy();
		return drain_cnt < LATENCY + 4;
	endfunction

	// clamp a signed magnitude to Q16.16, flag when clamped
	function automatic logic [63:0] clamp_q16(bit neg, logic [63:0] m, ref bit clip);
		logic [63:0] lim;
		lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
		if (m > lim) begin
			clip = 1'b1;
			return lim;
		end
		return m;
	endfunction

	// compute the normalized value of one raw word under the current registers
	function automatic norm_result_t normalize_sample(logic [31:0] raw);
		norm_result_t r;
		bit valid, clip, kn, qn;
		logic [63:0] km, qm, rem;
		logic [15:0] h;
		logic [31:0] w;
		logic [7:0] e;
		longint ival;
		int sh;
		logic signed [127:0] num, span, prod;
		valid = 1'b1;
		clip = 1'b0;
		kn = 1'b0;
		km = '0;
		case (fmt_r)
			rsn_pkg::FMT_U8: begin
				ival = raw[7:0];
				if (signed_r && raw[7]) ival -= 256;
				kn = ival < 0;
				km = (kn ? -ival : ival) << 16;
			end
			rsn_pkg::FMT_16: begin
				h = swap_r ? {raw[7:0], raw[15:8]} : raw[15:0];
				ival = h;
				if (signed_r) begin
					if (h == rsn_pkg::S16_NULL) begin
						valid = 1'b0;
						ival = 0;
					end else if (h == rsn_pkg::S16_LOW_A || h == rsn_pkg::S16_LOW_B)
						ival = -32768;
					else if (h == rsn_pkg::S16_HIGH_A || h == rsn_pkg::S16_HIGH_B)
						ival = 32767;
					else if (h[15]) ival -= 65536;
				end
				kn = ival < 0;
				km = (kn ? -ival : ival) << 16;
			end
			rsn_pkg::FMT_F32: begin
				w = swap_r ? {raw[7:0], raw[15:8], raw[23:16], raw[31:24]} : raw;
				e = w[30:23];
				if (w == rsn_pkg::F32_NULL) valid = 1'b0;
				else if (w == rsn_pkg::F32_ZERO_A || w == rsn_pkg::F32_ZERO_B) km = '0;
				else if (w == rsn_pkg::F32_ONE_A || w == rsn_pkg::F32_ONE_B) km = 64'd65536;
				else if (e != 8'h00 && e != 8'hFF) begin
					sh = int'(e) - 134;
					kn = w[31];
					if (sh > 8) km = 64'h1_0000_0000;
					else if (sh >= 0) km = {40'd0, 1'b1, w[22:0]} << sh;
					else if (-sh > 25) km = '0;
					else km = ({40'd0, 1'b1, w[22:0]} + (64'd1 << (-sh - 1))) >> -sh;
					if (km == 0) kn = 1'b0;
					km = clamp_q16(kn, km, clip);
				end else valid = 1'b0;
			end
			default: begin
				r.norm_value = '0;
				r.sample_valid = 1'b0;
				r.clipped = 1'b0;
				return r;
			end
		endcase
		// exact numerator k*scale + (offset - low) * 2^16
		prod = $signed({1'b0, km}) * $signed(scale_r);
		if (kn) prod = -prod;
		num = prod + (($signed(offset_r) - $signed(low_r)) <<< 16);
		span = $signed(high_r) - $signed(low_r);
		if (span == 0) begin
			clip = 1'b1;
			r.norm_value = num == 0 ? 32'd0 : (num < 0 ? 32'h8000_0000 : 32'h7FFF_FFFF);
		end else begin
			// round magnitude to nearest, ties away from zero
			qm = (num < 0 ? -num : num) / (span < 0 ? -span : span);
			rem = (num < 0 ? -num : num) % (span < 0 ? -span : span);
			if (2 * rem >= (span < 0 ? -span : span)) qm += 1;
			qn = (qm != 0) && ((num < 0) != (span < 0));
			qm = clamp_q16(qn, qm, clip);
			r.norm_value = qn ? 32'(-qm) : 32'(qm);
		end
		r.sample_valid = valid;
		r.clipped = clip;
		return r;
	endfunction

	function automatic logic [31:0] pick_word();
		logic [7:0] lo;
		lo = 8'($urandom_range(0, 4));
		case ($urandom_range(0, 5))
			0: return {16'($urandom), $urandom_range(0, 1) ? {8'h80, lo} : {lo, 8'h80}};
			1: return {$urandom_range(0, 1) ? 8'h3F : 8'hC7, 24'($urandom)};
			2: return 32'hFF7F_FFFB + $urandom_range(0, 4);
			3: return {$urandom_range(0, 1) ? 8'h80 : 8'h00, 24'($urandom)};
			default: return $urandom;
		endcase
	endfunction

	task automatic push_cfg(rsn_pkg::rsn_reg_t idx, logic [31:0] val);
		pending_q.push_back('{1'b1, idx, val});
	endtask

	task automatic push_sample(logic [31:0] val);
		pending_q.push_back('{1'b0, rsn_pkg::REG_SAMPLE_FORMAT, val});
	endtask

	// drive samples and register writes one beat at a time
	always @(negedge clk) begin
		bit s_busy, c_busy;
		if (arst_n) begin
			s_busy = samples.valid && !sample_taken;
			c_busy = cfg.valid && !cfg_taken;
			if (!s_busy && !c_busy) begin
				if (sample_gap > 0) begin
					sample_gap <= sample_gap - 1;
					samples.valid <= 1'b0;
					cfg.valid <= 1'b0;
				end else if (pending_q.size() > 0 && !pending_q[0].is_cfg) begin
					samples.valid <= 1'b1;
					samples.raw_word <= pending_q[0].word;
					cfg.valid <= 1'b0;
					void'(pending_q.pop_front());
					sample_gap <= $urandom_range(0, 4) == 0 ? $urandom_range(0, 4) : 0;
				end else if (pending_q.size() > 0 && expected_q.size() == 0 && !u_busy()
					&& !samples.valid) begin
					// register writes wait until the pipeline has drained
					cfg.valid <= 1'b1;
					cfg.index <= pending_q[0].reg_idx;
					cfg.data <= pending_q[0].word;
					void'(pending_q.pop_front());
				end else begin
					samples.valid <= 1'b0;
					cfg.valid <= 1'b0;
				end
			end
		end
	end

	// accept beats, predict, check, watch for a hang
	always @(posedge clk) begin
		norm_result_t exp_r;
		if (arst_n) begin
			sample_taken <= samples.valid && samples.ready;
			cfg_taken <= cfg.valid && cfg.ready;
			drain_cnt <= (expected_q.size() == 0) ? drain_cnt + 1 : 0;
			if (cfg.valid && cfg.ready) begin
				case (rsn_pkg::rsn_reg_t'(cfg.index))
					rsn_pkg::REG_SAMPLE_FORMAT: fmt_r = cfg.data[1:0];
					rsn_pkg::REG_SAMPLES_SIGNED: signed_r = cfg.data[0];
					rsn_pkg::REG_SWAP_BYTES: swap_r = cfg.data[0];
					rsn_pkg::REG_SCALE_FACTOR: scale_r = cfg.data;
					rsn_pkg::REG_OFFSET_VALUE: offset_r = cfg.data;
					rsn_pkg::REG_NORM_LOW: low_r = cfg.data;
					rsn_pkg::REG_NORM_HIGH: high_r = cfg.data;
					default: ;
				endcase
			end
			if (samples.valid && samples.ready)
				expected_q.push_back(normalize_sample(samples.raw_word));
			if (results.valid && results.ready) begin
				if (expected_q.size() == 0) begin
					$error("result beat with nothing expected");
					errors++;
				end else begin
					exp_r = expected_q.pop_front();
					if (results.norm_value !== exp_r.norm_value) begin
						$error("norm_value: expected %h, got %h", exp_r.norm_value,
							results.norm_value);
						errors++;
					end
					if (results.sample_valid !== exp_r.sample_valid) begin
						$error("sample_valid: expected %b, got %b", exp_r.sample_valid,
							results.sample_valid);
						errors++;
					end
					if (results.clipped !== exp_r.clipped) begin
						$error("clipped: expected %b, got %b", exp_r.clipped, results.clipped);
						errors++;
					end
				end
			end
			if ((samples.valid && samples.ready) || (results.valid && results.ready)
				|| (cfg.valid && cfg.ready) || drain_cnt < LATENCY + 8)
				idle_cycles <= 0;
			else if (pending_q.size() > 0 || expected_q.size() > 0)
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// stall the result side at random, with stall-free stretches
	always @(negedge clk) begin
		if (arst_n) begin
			if (results.valid && results.ready && ($urandom_range(0, 3) != 0)) begin
				results.ready <= 1'b0;
				result_gap <= $urandom_range(0, 4);
			end else if (!results.ready) begin
				if (result_gap == 0) results.ready <= 1'b1;
				else result_gap <= result_gap - 1;
			end
		end
	end

	// directed settings, then random phases
	initial begin
		logic [31:0] extremes[6];
		logic [15:0] s16_codes[6];
		extremes = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0001_0000, 32'hFFFF_0000, 32'h1};
		s16_codes = '{rsn_pkg::S16_NULL, rsn_pkg::S16_LOW_A, rsn_pkg::S16_LOW_B,
			rsn_pkg::S16_HIGH_A, rsn_pkg::S16_HIGH_B, 16'h7FFF};
		samples.valid = 1'b0;
		samples.raw_word = '0;
		cfg.valid = 1'b0;
		cfg.index = rsn_pkg::REG_SAMPLE_FORMAT;
		cfg.data = '0;
		results.ready = 1'b1;
		fmt_r = rsn_pkg::FMT_U8;
		signed_r = 1'b0;
		swap_r = 1'b0;
		scale_r = rsn_pkg::SCALE_RESET;
		offset_r = '0;
		low_r = '0;
		high_r = rsn_pkg::NORM_HIGH_RESET;
		// directed: reset settings, 8-bit extremes
		push_sample(32'h0000_0000);
		push_sample(32'hFFFF_FFFF);
		push_sample(32'h0000_0080);
		// signed 16-bit special codes, swapped and not
		push_cfg(rsn_pkg::REG_SAMPLE_FORMAT, 32'(rsn_pkg::FMT_16));
		push_cfg(rsn_pkg::REG_SAMPLES_SIGNED, 32'd1);
		push_cfg(rsn_pkg::REG_NORM_HIGH, 32'h7FFF_FFFF);
		foreach (s16_codes[i])
			push_sample({16'hABCD, s16_codes[i]});
		push_cfg(rsn_pkg::REG_SWAP_BYTES, 32'd1);
		push_sample(32'h0000_0080);
		push_sample(32'h0000_0480);
		// float codes and non-normal values
		push_cfg(rsn_pkg::REG_SAMPLE_FORMAT, 32'(rsn_pkg::FMT_F32));
		push_cfg(rsn_pkg::REG_SWAP_BYTES, 32'd0);
		for (int i = 0; i < 5; i++) push_sample(rsn_pkg::F32_NULL + 32'(i));
		push_sample(32'h0000_0000);
		push_sample(32'h0000_0001);
		push_sample(32'h7F80_0000);
		push_sample(32'hFFC0_0000);
		push_sample(32'h4F00_0000);
		push_sample(32'hCF00_0000);
		push_sample(32'h3F80_0000);
		// zero span, then unknown format
		push_cfg(rsn_pkg::REG_NORM_HIGH, 32'h0);
		push_sample(32'h3F80_0000);
		push_sample(32'hBF80_0000);
		push_cfg(rsn_pkg::REG_SAMPLE_FORMAT, 32'd3);
		push_sample(32'h1234_5678);
		// random phases across register settings
		for (int ph = 0; ph < 33; ph++) begin
			push_cfg(rsn_pkg::REG_SAMPLE_FORMAT,
				$urandom_range(0, 12) == 0 ? 32'd3 : $urandom_range(0, 2));
			push_cfg(rsn_pkg::REG_SAMPLES_SIGNED, $urandom);
			push_cfg(rsn_pkg::REG_SWAP_BYTES, $urandom);
			push_cfg(rsn_pkg::REG_SCALE_FACTOR, ph < 6 ? extremes[ph] :
				($urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 18) - (1 << 17)));
			push_cfg(rsn_pkg::REG_OFFSET_VALUE, ph < 6 ? extremes[5 - ph] :
				($urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 20)));
			push_cfg(rsn_pkg::REG_NORM_LOW, ph < 6 ? extremes[(ph + 2) % 6] :
				($urandom_range(0, 1) ? $urandom : $urandom_range(0, 1 << 18)));
			push_cfg(rsn_pkg::REG_NORM_HIGH, ph < 6 ? extremes[(ph + 4) % 6] :
				($urandom_range(0, 1) ? $urandom : $urandom_range(1 << 18, 1 << 24)));
			for (int i = 0; i < 50; i++) push_sample(pick_word());
		end
		// also write the out-of-range index once
		pending_q.push_back('{1'b1, rsn_pkg::rsn_reg_t'(3'd7), 32'hFFFF_FFFF});
		push_sample(32'h0000_0001);
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (pending_q.size() == 0 && !samples.valid && !cfg.valid);
		wait (expected_q.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0 && expected_q.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
